FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CRCL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CRCL_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CRCL_ASSERT(lbl, clk, rst_n, prop, msg)

`define CRCL_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: sv/crcl_pkg.sv
// ----------------------------------------------------------------------------
// crcl_pkg
// Types, character codes and CRC-16 helpers for the command/reply link.
// ----------------------------------------------------------------------------
package crcl_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 8;
    localparam int TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_OPEN = 8'h28;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_START = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT     = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic MODE_TX = 1'b0;

    localparam logic [1:0] SLOT_ECHO = 2'd0;
    localparam logic [1:0] SLOT_HI   = 2'd1;
    localparam logic [1:0] SLOT_LO   = 2'd2;
    localparam logic [1:0] SLOT_CR   = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic              four;
        logic [BYTE_W-1:0] echo;
        logic [BYTE_W-1:0] crc_hi;
        logic [BYTE_W-1:0] crc_lo;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  len;
    } t_burst;

    // polynomial 0x1021 folded over one nibble
    function automatic logic [CRC_W-1:0] crc_nib_tab(input logic [3:0] idx);
        logic [CRC_W-1:0] v;
        case (idx)
            4'h0: v = 16'h0000;
            4'h1: v = 16'h1021;
            4'h2: v = 16'h2042;
            4'h3: v = 16'h3063;
            4'h4: v = 16'h4084;
            4'h5: v = 16'h50A5;
            4'h6: v = 16'h60C6;
            4'h7: v = 16'h70E7;
            4'h8: v = 16'h8108;
            4'h9: v = 16'h9129;
            4'hA: v = 16'hA14A;
            4'hB: v = 16'hB16B;
            4'hC: v = 16'hC18C;
            4'hD: v = 16'hD1AD;
            4'hE: v = 16'hE1CE;
            4'hF: v = 16'hF1EF;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] crc_nibble(input logic [CRC_W-1:0] crc,
                                                    input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return {crc[11:0], 4'h0} ^ crc_nib_tab(idx);
    endfunction

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        return crc_nibble(crc_nibble(crc, b[7:4]), b[3:0]);
    endfunction

    function automatic logic [BYTE_W-1:0] escape_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b == CHAR_OPEN || b == CHAR_CR || b == CHAR_LF) begin
            r = b + 8'd1;
        end
        return r;
    endfunction

endpackage

FILE: sv/crc_framed_command_reply_link.sv
// ----------------------------------------------------------------------------
// crc_framed_command_reply_link
// CRC-16 command framer and reply checker for a byte serial link.
// ----------------------------------------------------------------------------
// Input stream: tdata = data byte, tuser = mode (0 command, 1 reply byte),
// tlast = last command byte. Output stream: tuser = result kind (0 byte to
// send, 1 reply verdict), tlast = last result of the input transfer, tdata =
// tx_byte, status and reply_length packed from bit 0.
// A command byte gives one transfer (its echo); a last command byte gives
// four: echo, escaped CRC high, escaped CRC low and CR. A reply byte gives no
// transfer until the CR or the length limit, then one verdict.
// A result passes from its input transfer through the input register, then
// the result register; the core between them is combinational.
// Throughput: one input transfer per cycle while each item gives at most one
// result and the receiver takes every result; a last command byte holds the
// input while its four results drain from the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more transfer before tready drops.
// Reset clears both CRCs, the reply count and all pending results.
// ----------------------------------------------------------------------------
module crc_framed_command_reply_link #(
    parameter int MAX_REPLY = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [7:0] data_byte
    input  logic                         i_s_axis_tuser,  // [0] mode
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [7:0] tx_byte, [10:8] status, [18:11] reply_length, [23:19] zero
    output logic [crcl_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic                         o_m_axis_tuser,  // [0] result_kind
    output logic                         o_m_axis_tlast
);
    import crcl_pkg::*;

    logic     w_in_valid;
    t_in_item w_item;
    logic     w_room;
    logic     w_take;
    logic     w_has_result;
    t_burst   w_burst;

    assign w_take = w_in_valid && w_room;

    crcl_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_take          (w_take),
        .o_valid         (w_in_valid),
        .o_item          (w_item)
    );

    crcl_core #(
        .MAX_REPLY (MAX_REPLY)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_item       (w_item),
        .o_has_result (w_has_result),
        .o_burst      (w_burst)
    );

    crcl_out_seq u_out_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_take),
        .i_has_result    (w_has_result),
        .i_burst         (w_burst),
        .o_room          (w_room),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: sv/crcl_in_reg.sv
// ----------------------------------------------------------------------------
// crcl_in_reg
// Input register: holds one accepted transfer until the core takes it.
// ----------------------------------------------------------------------------
module crcl_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,
    input  logic              i_s_axis_tuser,
    input  logic              i_s_axis_tlast,
    input  logic              i_take,
    output logic              o_valid,
    output crcl_pkg::t_in_item o_item
);
    import crcl_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_load;

    assign o_s_axis_tready = !r_valid || i_take;
    assign w_load          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.mode      <= i_s_axis_tuser;
            r_item.data_byte <= i_s_axis_tdata;
            r_item.last      <= i_s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/crcl_core.sv
// ----------------------------------------------------------------------------
// crcl_core
// Transmit CRC and receive framing state; builds the results of one item.
// ----------------------------------------------------------------------------
module crcl_core #(
    parameter int MAX_REPLY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  crcl_pkg::t_in_item i_item,
    output logic               o_has_result,
    output crcl_pkg::t_burst   o_burst
);
    import crcl_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_REPLY);

    logic [CRC_W-1:0] r_tx_crc, n_tx_crc;
    logic [CRC_W-1:0] r_rx_crc, n_rx_crc;
    logic [CRC_W-1:0] r_held,   n_held;
    logic [LEN_W-1:0] r_count,  n_count;
    logic             r_start,  n_start;

    logic [CRC_W-1:0]  w_tx_next;
    logic [CRC_W-1:0]  w_rx_next;
    logic [LEN_W-1:0]  w_cnt1;
    logic              w_start;
    logic [CRC_W-1:0]  w_want;
    logic [BYTE_W-1:0] w_b;

    assign w_b       = i_item.data_byte;
    assign w_tx_next = crc_byte(r_tx_crc, w_b);
    assign w_rx_next = crc_byte(r_rx_crc, r_held[15:8]);
    assign w_cnt1    = r_count + LEN_W'(1);
    assign w_start   = (r_count == '0) ? (w_b == CHAR_OPEN) : r_start;
    assign w_want    = {escape_byte(r_rx_crc[15:8]), escape_byte(r_rx_crc[7:0])};

    always_comb begin
        n_tx_crc       = r_tx_crc;
        n_rx_crc       = r_rx_crc;
        n_held         = r_held;
        n_count        = r_count;
        n_start        = r_start;
        o_has_result   = 1'b0;
        o_burst.kind   = KIND_TX;
        o_burst.four   = 1'b0;
        o_burst.echo   = w_b;
        o_burst.crc_hi = escape_byte(w_tx_next[15:8]);
        o_burst.crc_lo = escape_byte(w_tx_next[7:0]);
        o_burst.status = ST_OK;
        o_burst.len    = '0;
        if (i_item.mode == MODE_TX) begin
            o_has_result = 1'b1;
            o_burst.four = i_item.last;
            n_tx_crc     = i_item.last ? '0 : w_tx_next;
        end else if (w_b != CHAR_CR) begin
            n_start = w_start;
            if (r_count >= LEN_W'(2)) begin
                n_rx_crc = w_rx_next;
            end
            n_held  = {r_held[7:0], w_b};
            n_count = w_cnt1;
            if (w_cnt1 >= MAX_LEN) begin
                o_has_result   = 1'b1;
                o_burst.kind   = KIND_VERDICT;
                o_burst.status = ST_OVERFLOW;
                o_burst.len    = MAX_LEN;
                n_rx_crc       = '0;
                n_held         = '0;
                n_count        = '0;
                n_start        = 1'b0;
            end
        end else begin
            o_has_result = 1'b1;
            o_burst.kind = KIND_VERDICT;
            o_burst.len  = w_cnt1;
            if (!w_start) begin
                o_burst.status = ST_BAD_START;
            end else if (w_cnt1 < LEN_W'(4)) begin
                o_burst.status = ST_SHORT;
            end else if (r_held != w_want) begin
                o_burst.status = ST_MISMATCH;
            end
            n_rx_crc = '0;
            n_held   = '0;
            n_count  = '0;
            n_start  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_crc <= '0;
            r_rx_crc <= '0;
            r_held   <= '0;
            r_count  <= '0;
            r_start  <= 1'b0;
        end else if (i_take) begin
            r_tx_crc <= n_tx_crc;
            r_rx_crc <= n_rx_crc;
            r_held   <= n_held;
            r_count  <= n_count;
            r_start  <= n_start;
        end
    end

endmodule

FILE: sv/crcl_out_seq.sv
// ----------------------------------------------------------------------------
// crcl_out_seq
// Result register: holds the results of one item and sends them in order.
// ----------------------------------------------------------------------------
module crcl_out_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_has_result,
    input  crcl_pkg::t_burst               i_burst,
    output logic                           o_room,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [crcl_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import crcl_pkg::*;

    `include "assert_macros.svh"

    logic        r_busy, n_busy;
    logic [1:0]  r_idx,  n_idx;
    t_burst      r_burst;
    logic        w_last;
    logic        w_done;
    logic [BYTE_W-1:0] w_byte;

    assign w_last = !r_burst.four || (r_idx == SLOT_CR);
    assign w_done = r_busy && i_m_axis_tready && w_last;
    assign o_room = !r_busy || w_done;

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_load) begin
            n_busy = i_has_result;
            n_idx  = SLOT_ECHO;
        end else if (w_done) begin
            n_busy = 1'b0;
            n_idx  = SLOT_ECHO;
        end else if (r_busy && i_m_axis_tready) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= SLOT_ECHO;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    always_comb begin
        case (r_idx)
            SLOT_ECHO: w_byte = r_burst.echo;
            SLOT_HI:   w_byte = r_burst.crc_hi;
            SLOT_LO:   w_byte = r_burst.crc_lo;
            SLOT_CR:   w_byte = CHAR_CR;
            default:   w_byte = r_burst.echo;
        endcase
        if (r_burst.kind == KIND_VERDICT) begin
            w_byte = '0;
        end
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tuser  = r_burst.kind;
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tdata  = {5'd0, r_burst.len, r_burst.status, w_byte};

    `CRCL_ASSERT(a_load_room, i_clk, i_rst_n, i_load |-> o_room, "load while results pending")
    `CRCL_ASSERT(a_idx_four, i_clk, i_rst_n, (r_idx != SLOT_ECHO) |-> (r_busy && r_burst.four), "slot advance outside a four-result burst")
    `CRCL_ASSERT(a_cr_slot, i_clk, i_rst_n, (r_busy && r_idx == SLOT_CR) |-> (o_m_axis_tdata[7:0] == CHAR_CR && o_m_axis_tlast), "closing slot is not CR")
    `CRCL_NEVER(a_verdict_byte, i_clk, i_rst_n, r_busy && r_burst.kind == KIND_VERDICT && o_m_axis_tdata[7:0] != '0, "verdict carries a byte")

endmodule
